// ===== src/ini_text_tokenizer_defines.svh =====
// Assertion macros used by the checker file of the tokenizer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef INI_TEXT_TOKENIZER_DEFINES_SVH
`define INI_TEXT_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ini_tok_pkg.sv =====
package ini_tok_pkg;

  // Width of the internal line and column counters; both saturate.
  localparam int unsigned LineBits   = 16;
  localparam int unsigned ColumnBits = 16;

  // Widths of the line and column fields on the result port.
  localparam int unsigned LineNoW = 16;
  localparam int unsigned ColNoW  = 16;

  // Keyword matcher: index runs from zero up to one past the keyword length.
  localparam int unsigned KwIdxW     = 4;
  localparam logic [KwIdxW-1:0] KeywordLen = 4'd7;

  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChVtab     = 8'h0B;
  localparam logic [7:0] ChFormfeed = 8'h0C;
  localparam logic [7:0] ChReturn   = 8'h0D;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChDquote   = 8'h22;
  localparam logic [7:0] ChHash     = 8'h23;
  localparam logic [7:0] ChSquote   = 8'h27;
  localparam logic [7:0] ChLParen   = 8'h28;
  localparam logic [7:0] ChRParen   = 8'h29;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChEquals   = 8'h3D;
  localparam logic [7:0] ChAt       = 8'h40;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;

  typedef enum logic [1:0] {
    KindValue = 2'd0,
    KindToken = 2'd1,
    KindError = 2'd2,
    KindEnd   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    TokSection = 3'd0,
    TokAssign  = 3'd1,
    TokQuoted  = 3'd2,
    TokWord    = 3'd3,
    TokInclude = 3'd4,
    TokOpen    = 3'd5,
    TokClose   = 3'd6,
    TokComma   = 3'd7
  } tok_e;

  typedef enum logic [2:0] {
    ErrNone            = 3'd0,
    ErrSectionNewline  = 3'd1,
    ErrSectionReserved = 3'd2,
    ErrSectionEnd      = 3'd3,
    ErrSectionEmpty    = 3'd4,
    ErrQuoteEnd        = 3'd5,
    ErrBadInclude      = 3'd6
  } err_e;

  // One result word.
  typedef struct packed {
    kind_e               kind;
    tok_e                token_type;
    logic [7:0]          value_byte;
    err_e                error_code;
    logic [LineNoW-1:0]  line_no;
    logic [ColNoW-1:0]   column_no;
    logic                last;
  } res_t;

  // All results caused by one input word: a count of zero to two.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } lex_out_t;

  function automatic res_t mk_res(kind_e k, tok_e t, logic [7:0] b, err_e e,
                                  logic [LineNoW-1:0] ln, logic [ColNoW-1:0] cn);
    res_t r;
    r.kind       = k;
    r.token_type = t;
    r.value_byte = b;
    r.error_code = e;
    r.line_no    = ln;
    r.column_no  = cn;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic byte_reserved(logic [7:0] c);
    return (c == ChLParen) || (c == ChRParen) || (c == ChComma) || (c == ChSquote) ||
           (c == ChDquote) || (c == ChLBracket) || (c == ChRBracket) || (c == ChAt) ||
           (c == ChHash) || (c == ChEquals);
  endfunction

  function automatic logic byte_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNewline) || (c == ChVtab) ||
           (c == ChFormfeed) || (c == ChReturn);
  endfunction

  // Letters of the include keyword.
  function automatic logic [7:0] kw_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h69;
      3'd1: c = 8'h6E;
      3'd2: c = 8'h63;
      3'd3: c = 8'h6C;
      3'd4: c = 8'h75;
      3'd5: c = 8'h64;
      3'd6: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ini_text_tokenizer.sv =====
// Channel | Dir | Handshake              | Payload
// input   | in  | in_valid_i, in_stall_o | ch_i, end_of_input_i
// result  | out | out_valid_o, out_stall_i | kind_o, token_type_o, value_byte_o,
//         |     |                        | error_code_o, line_no_o, column_no_o, last_o
//
// A word is taken into the input register, lexed from there once the buffer has room,
// and its results land in a two-entry output buffer, from which the first result shows.
// One input word is taken per cycle while each causes at most one result and the
// result side does not stall; a word that causes two results holds the next word in
// the input register while the buffer drains. Reset clears the lexer state and empties
// both registers. A stall on the result side holds the shown word and, once the buffer
// cannot drain, raises in_stall_o.
module ini_text_tokenizer import ini_tok_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          ch_i,
  input  logic                end_of_input_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [2:0]          token_type_o,
  output logic [7:0]          value_byte_o,
  output logic [2:0]          error_code_o,
  output logic [LineNoW-1:0]  line_no_o,
  output logic [ColNoW-1:0]   column_no_o,
  output logic                last_o
);

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       eoi_q;
  logic       buf_free;
  logic       step;
  lex_out_t   lex_out;
  res_t       res;

  // The input register moves on to the lexer whenever the buffer can take its results.
  assign step       = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ch_q  <= ch_i;
      eoi_q <= end_of_input_i;
    end
  end

  ini_tok_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (ch_q),
    .eoi_i  (eoi_q),
    .out_o  (lex_out)
  );

  ini_tok_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (lex_out),
    .free_o  (buf_free),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (res)
  );

  assign kind_o       = res.kind;
  assign token_type_o = res.token_type;
  assign value_byte_o = res.value_byte;
  assign error_code_o = res.error_code;
  assign line_no_o    = res.line_no;
  assign column_no_o  = res.column_no;
  assign last_o       = res.last;

endmodule

// ===== src/ini_tok_lexer.sv =====
module ini_tok_lexer import ini_tok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       eoi_i,
  output lex_out_t   out_o
);

  typedef enum logic [6:0] {
    ModeTop     = 7'b0000001,
    ModeComment = 7'b0000010,
    ModeSection = 7'b0000100,
    ModeQuoted  = 7'b0001000,
    ModeWord    = 7'b0010000,
    ModeInclude = 7'b0100000,
    ModeHalted  = 7'b1000000
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [LineBits-1:0]   line_q, line_d, line_inc;
  logic [ColumnBits-1:0] col_q, col_d, col_inc, tok_q, tok_d;
  logic                  name_ne_q, name_ne_d;
  logic                  dq_q, dq_d;
  logic [KwIdxW-1:0]     kw_idx_q, kw_idx_d;
  logic                  kw_mis_q, kw_mis_d;

  logic [LineNoW-1:0]    ln;
  logic [ColNoW-1:0]     cn, tn;
  logic                  kw_bad;
  logic                  pre_v, top_v, do_top;
  res_t                  pre_r, top_r, end_r;
  logic [1:0]            cnt;

  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
  assign col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;
  assign ln       = LineNoW'(line_q);
  assign cn       = ColNoW'(col_q);
  assign tn       = ColNoW'(tok_q);
  assign kw_bad   = kw_mis_q || (kw_idx_q != KeywordLen);

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    tok_d     = tok_q;
    name_ne_d = name_ne_q;
    dq_d      = dq_q;
    kw_idx_d  = kw_idx_q;
    kw_mis_d  = kw_mis_q;
    pre_v     = 1'b0;
    top_v     = 1'b0;
    do_top    = 1'b0;
    pre_r     = mk_res(KindValue, TokSection, 8'h00, ErrNone, ln, cn);
    top_r     = pre_r;
    end_r     = mk_res(KindEnd, TokSection, 8'h00, ErrNone, ln, cn);

    if (eoi_i) begin
      case (mode_q)
        ModeSection: begin
          pre_v = 1'b1;
          pre_r = mk_res(KindError, TokSection, 8'h00, ErrSectionEnd, ln, cn);
        end
        ModeQuoted: begin
          pre_v = 1'b1;
          pre_r = mk_res(KindError, TokSection, 8'h00, ErrQuoteEnd, ln, cn);
        end
        ModeWord: begin
          pre_v = 1'b1;
          pre_r = mk_res(KindToken, TokWord, 8'h00, ErrNone, ln, tn);
        end
        ModeInclude: begin
          pre_v = 1'b1;
          if (kw_bad) begin
            pre_r = mk_res(KindError, TokSection, 8'h00, ErrBadInclude, ln, cn);
          end else begin
            pre_r = mk_res(KindToken, TokInclude, 8'h00, ErrNone, ln, tn);
          end
        end
        default: ;
      endcase
      mode_d    = ModeTop;
      line_d    = LineBits'(1);
      col_d     = '0;
      tok_d     = '0;
      name_ne_d = 1'b0;
      dq_d      = 1'b0;
      kw_idx_d  = '0;
      kw_mis_d  = 1'b0;
    end else begin
      case (mode_q)
        ModeTop: begin
          do_top = 1'b1;
        end
        ModeComment: begin
          if (ch_i == ChNewline) begin
            line_d = line_inc;
            col_d  = '0;
            mode_d = ModeTop;
          end else begin
            col_d = col_inc;
          end
        end
        ModeSection: begin
          if (ch_i == ChRBracket) begin
            pre_v = 1'b1;
            if (!name_ne_q) begin
              pre_r  = mk_res(KindError, TokSection, 8'h00, ErrSectionEmpty, ln, cn);
              mode_d = ModeHalted;
            end else begin
              pre_r  = mk_res(KindToken, TokSection, 8'h00, ErrNone, ln, tn);
              mode_d = ModeTop;
            end
          end else if (ch_i == ChNewline) begin
            pre_v  = 1'b1;
            pre_r  = mk_res(KindError, TokSection, 8'h00, ErrSectionNewline, ln, cn);
            mode_d = ModeHalted;
          end else if (byte_reserved(ch_i)) begin
            pre_v  = 1'b1;
            pre_r  = mk_res(KindError, TokSection, 8'h00, ErrSectionReserved, ln, cn);
            mode_d = ModeHalted;
          end else begin
            pre_v     = 1'b1;
            pre_r     = mk_res(KindValue, TokSection, ch_i, ErrNone, ln, cn);
            col_d     = col_inc;
            name_ne_d = 1'b1;
          end
        end
        ModeQuoted: begin
          pre_v = 1'b1;
          if (ch_i == (dq_q ? ChDquote : ChSquote)) begin
            pre_r  = mk_res(KindToken, TokQuoted, 8'h00, ErrNone, ln, tn);
            mode_d = ModeTop;
          end else begin
            pre_r = mk_res(KindValue, TokQuoted, ch_i, ErrNone, ln, cn);
            col_d = col_inc;
          end
        end
        ModeWord: begin
          pre_v = 1'b1;
          if (byte_blank(ch_i) || byte_reserved(ch_i)) begin
            pre_r  = mk_res(KindToken, TokWord, 8'h00, ErrNone, ln, tn);
            mode_d = ModeTop;
            do_top = 1'b1;
          end else begin
            pre_r = mk_res(KindValue, TokWord, ch_i, ErrNone, ln, cn);
            col_d = col_inc;
          end
        end
        ModeInclude: begin
          if ((ch_i == ChSpace) || (ch_i == ChTab)) begin
            pre_v = 1'b1;
            if (kw_bad) begin
              pre_r  = mk_res(KindError, TokSection, 8'h00, ErrBadInclude, ln, cn);
              mode_d = ModeHalted;
            end else begin
              pre_r  = mk_res(KindToken, TokInclude, 8'h00, ErrNone, ln, tn);
              mode_d = ModeTop;
              do_top = 1'b1;
            end
          end else begin
            if ((kw_idx_q >= KeywordLen) || (kw_char(kw_idx_q[2:0]) != ch_i)) begin
              kw_mis_d = 1'b1;
            end
            if (kw_idx_q <= KeywordLen) begin
              kw_idx_d = kw_idx_q + 1'b1;
            end
            col_d = col_inc;
          end
        end
        default: ;
      endcase

      // Top-level handling; a word or keyword that ends here hands its byte on.
      if (do_top) begin
        if (ch_i == ChNewline) begin
          line_d = line_inc;
          col_d  = '0;
        end else if (ch_i == ChHash) begin
          col_d  = col_inc;
          mode_d = ModeComment;
        end else if (ch_i == ChLBracket) begin
          tok_d     = col_q;
          name_ne_d = 1'b0;
          mode_d    = ModeSection;
        end else if (ch_i == ChEquals) begin
          top_v = 1'b1;
          top_r = mk_res(KindToken, TokAssign, 8'h00, ErrNone, ln, cn);
          col_d = col_inc;
        end else if (byte_blank(ch_i)) begin
          col_d = col_inc;
        end else if (ch_i == ChAt) begin
          tok_d    = col_q;
          kw_idx_d = '0;
          kw_mis_d = 1'b0;
          mode_d   = ModeInclude;
        end else if ((ch_i == ChSquote) || (ch_i == ChDquote)) begin
          tok_d  = col_q;
          dq_d   = (ch_i == ChDquote);
          mode_d = ModeQuoted;
        end else if (ch_i == ChLParen) begin
          top_v = 1'b1;
          top_r = mk_res(KindToken, TokOpen, 8'h00, ErrNone, ln, cn);
          col_d = col_inc;
        end else if (ch_i == ChRParen) begin
          top_v = 1'b1;
          top_r = mk_res(KindToken, TokClose, 8'h00, ErrNone, ln, cn);
          col_d = col_inc;
        end else if (ch_i == ChComma) begin
          top_v = 1'b1;
          top_r = mk_res(KindToken, TokComma, 8'h00, ErrNone, ln, cn);
          col_d = col_inc;
        end else begin
          tok_d  = col_q;
          top_v  = 1'b1;
          top_r  = mk_res(KindValue, TokWord, ch_i, ErrNone, ln, cn);
          col_d  = col_inc;
          mode_d = ModeWord;
        end
      end
    end
  end

  // Results in order: the mode's own result, then the top-level one, then end of document.
  assign cnt = {1'b0, pre_v} + {1'b0, top_v} + {1'b0, eoi_i};

  always_comb begin
    out_o.cnt = cnt;
    out_o.r0  = pre_v ? pre_r : (top_v ? top_r : end_r);
    out_o.r1  = (pre_v && top_v) ? top_r : end_r;
    out_o.r0.last = (cnt == 2'd1);
    out_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeTop;
      line_q    <= LineBits'(1);
      col_q     <= '0;
      tok_q     <= '0;
      name_ne_q <= 1'b0;
      dq_q      <= 1'b0;
      kw_idx_q  <= '0;
      kw_mis_q  <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      line_q    <= line_d;
      col_q     <= col_d;
      tok_q     <= tok_d;
      name_ne_q <= name_ne_d;
      dq_q      <= dq_d;
      kw_idx_q  <= kw_idx_d;
      kw_mis_q  <= kw_mis_d;
    end
  end

endmodule

// ===== src/ini_tok_outbuf.sv =====
module ini_tok_outbuf import ini_tok_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lex_out_t data_i,
  output logic     free_o,
  input  logic     stall_i,
  output logic     valid_o,
  output res_t     res_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  // The buffer takes a new set of results only when it is empty or its last result leaves in this cycle.
  assign free_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign res_o   = slot0_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i) begin
      cnt_d   = data_i.cnt;
      slot0_d = data_i.r0;
      slot1_d = data_i.r1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// ===== src/ini_tok_checker.sv =====
`include "ini_text_tokenizer_defines.svh"

module ini_tok_checker import ini_tok_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic [2:0]         token_type_o,
  input logic [7:0]         value_byte_o,
  input logic [2:0]         error_code_o,
  input logic [LineNoW-1:0] line_no_o,
  input logic [ColNoW-1:0]  column_no_o,
  input logic               last_o
);

  // Input is held back only while results are waiting.
  `ITT_ASSERT_IMP(a_stall_needs_output, in_stall_o, out_valid_o, "input stalled with no result")

  // The second result of a word is already buffered when the first is taken.
  `ITT_ASSERT_NXT(a_second_follows, out_valid_o && !out_stall_i && !last_o, out_valid_o, "second result missing")

  // An error that is not last was raised at end of input, so end of document follows.
  `ITT_ASSERT_NXT(a_error_then_end, out_valid_o && !out_stall_i && (kind_o == KindError) && !last_o, out_valid_o && (kind_o == KindEnd) && last_o, "error not followed by end of document")

  // A stalled result word holds.
  `ITT_ASSERT_NXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(token_type_o) && $stable(value_byte_o) && $stable(error_code_o) && $stable(line_no_o) && $stable(column_no_o) && $stable(last_o), "stalled result changed")

endmodule

bind ini_text_tokenizer ini_tok_checker u_checker (.*);
